// File: sv/vertex_rotate_project_defines.svh
// assertion helpers for the vertex rotate and project block
`ifndef VERTEX_ROTATE_PROJECT_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VRP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("vertex_rotate_project check failed");
`define VRP_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("vertex_rotate_project check failed");
`else
`define VRP_ASSERT(lbl, prop)
`define VRP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: sv/vrp_pkg.sv
package vrp_pkg;
	localparam int INDEX_BITS_DEF = 16;
	localparam int QB = 21;
	localparam int NUM_W = 54;
	localparam int DEN_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int COORD_W = 24;
	localparam int SCR_W = 20;
	localparam logic signed [SCR_W-1:0] SAT_MAX = 20'sh7FFFF;
	localparam logic signed [SCR_W-1:0] SAT_MIN = 20'sh80000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PITCH_COS = 3'd0,
		REG_PITCH_SIN = 3'd1,
		REG_YAW_COS = 3'd2,
		REG_YAW_SIN = 3'd3,
		REG_FOCAL = 3'd4,
		REG_DEPTH_OFF = 3'd5,
		REG_WIDTH = 3'd6,
		REG_HEIGHT = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic en;
		logic valid;
	} pipe_ctl_t;
endpackage

// File: sv/vrp_div.sv
module vrp_div #(
	parameter int TAG_W = 8
) (
	input logic clk,
	input logic arst_n,
	input vrp_pkg::pipe_ctl_t ctl,
	input logic [vrp_pkg::NUM_W-1:0] num_x,
	input logic [vrp_pkg::NUM_W-1:0] num_y,
	input logic [vrp_pkg::DEN_W-1:0] den,
	input logic [TAG_W-1:0] tag,
	output logic out_valid,
	output logic [vrp_pkg::QB-1:0] quo_x,
	output logic [vrp_pkg::QB-1:0] quo_y,
	output logic [TAG_W-1:0] out_tag
);
	import vrp_pkg::*;

	logic vld_s [QB];
	logic [NUM_W-1:0] rx_s [QB];
	logic [NUM_W-1:0] ry_s [QB];
	logic [QB-1:0] qx_s [QB];
	logic [QB-1:0] qy_s [QB];
	logic [DEN_W-1:0] den_s [QB];
	logic [TAG_W-1:0] tag_s [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int B = QB - 1 - k;
		logic v_in;
		logic [NUM_W-1:0] rx_in, ry_in, trial;
		logic [QB-1:0] qx_in, qy_in;
		logic [DEN_W-1:0] d_in;
		logic [TAG_W-1:0] t_in;
		if (k == 0) begin : g_first
			assign v_in = ctl.valid;
			assign rx_in = num_x;
			assign ry_in = num_y;
			assign qx_in = '0;
			assign qy_in = '0;
			assign d_in = den;
			assign t_in = tag;
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign rx_in = rx_s[k-1];
			assign ry_in = ry_s[k-1];
			assign qx_in = qx_s[k-1];
			assign qy_in = qy_s[k-1];
			assign d_in = den_s[k-1];
			assign t_in = tag_s[k-1];
		end
		assign trial = NUM_W'(d_in) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				den_s[k] <= d_in;
				tag_s[k] <= t_in;
				if (rx_in >= trial) begin
					rx_s[k] <= rx_in - trial;
					qx_s[k] <= qx_in | (QB'(1) << B);
				end else begin
					rx_s[k] <= rx_in;
					qx_s[k] <= qx_in;
				end
				if (ry_in >= trial) begin
					ry_s[k] <= ry_in - trial;
					qy_s[k] <= qy_in | (QB'(1) << B);
				end else begin
					ry_s[k] <= ry_in;
					qy_s[k] <= qy_in;
				end
			end
		end
	end

	assign out_valid = vld_s[QB-1];
	assign quo_x = qx_s[QB-1];
	assign quo_y = qy_s[QB-1];
	assign out_tag = tag_s[QB-1];
endmodule

// File: sv/vertex_rotate_project.sv
// channel   dir  handshake                tdata / tuser / tlast
// s_axis    in   s_tvalid, s_tready       x, y, z, index / - / last_vertex
// m_axis    out  m_tvalid, m_tready       pix_x, pix_y, index / depth_invalid / last
// cfg       in   cfg_valid, cfg_ready     cfg_index, cfg_data
// one word per cycle unless the output register holds a word and m_tready is low;
// 6 arithmetic stages, 21 divider stages one quotient bit each, output register
// the divider pipeline sets the latency, each of its stages is one compare and subtract per quotient
// a stall at the output freezes every stage, nothing is dropped or repeated
// asynchronous reset clears valid bits and loads register defaults
module vertex_rotate_project #(
	parameter int INDEX_BITS = vrp_pkg::INDEX_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// x[23:0] y[47:24] z[71:48] index, zero pad
	input logic [((72 + INDEX_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	input logic s_tlast,
	output logic m_tvalid,
	input logic m_tready,
	// pix_x[19:0] pix_y[39:20] index, zero pad
	output logic [((40 + INDEX_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	// depth_invalid
	output logic [0:0] m_tuser,
	output logic m_tlast,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [vrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [vrp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import vrp_pkg::*;
	`include "vertex_rotate_project_defines.svh"

	localparam int OUT_W = ((40 + INDEX_BITS + 7) / 8) * 8;
	localparam int TAG_W = INDEX_BITS + 6;

	logic signed [15:0] pitch_cos_q, pitch_sin_q, yaw_cos_q, yaw_sin_q;
	logic [15:0] focal_q;
	logic signed [23:0] depth_off_q;
	logic [13:0] width_q, height_q;

	logic en;
	logic out_vld_q;
	pipe_ctl_t ctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_cos_q <= 16'sd16384;
			pitch_sin_q <= '0;
			yaw_cos_q <= 16'sd16384;
			yaw_sin_q <= '0;
			focal_q <= 16'd3200;
			depth_off_q <= 24'sd98304;
			width_q <= 14'd1280;
			height_q <= 14'd720;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PITCH_COS: pitch_cos_q <= cfg_data[15:0];
				REG_PITCH_SIN: pitch_sin_q <= cfg_data[15:0];
				REG_YAW_COS: yaw_cos_q <= cfg_data[15:0];
				REG_YAW_SIN: yaw_sin_q <= cfg_data[15:0];
				REG_FOCAL: focal_q <= cfg_data[15:0];
				REG_DEPTH_OFF: depth_off_q <= cfg_data;
				REG_WIDTH: width_q <= cfg_data[13:0];
				REG_HEIGHT: height_q <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	assign en = !out_vld_q || m_tready;
	assign s_tready = en;

	logic signed [COORD_W-1:0] vx, vy, vz;
	assign vx = s_tdata[23:0];
	assign vy = s_tdata[47:24];
	assign vz = s_tdata[71:48];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [INDEX_BITS-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// first rotation products
	logic signed [39:0] p_cx_s1, p_sz_s1, p_sx_s1, p_cz_s1;
	logic signed [COORD_W-1:0] y_s1;
	// first rotation rounding
	logic signed [40:0] sum_x1, sum_z1;
	logic signed [26:0] x1_s2, y1_s2, z1_s2;
	// second rotation products
	logic signed [42:0] p_cy_s3, p_sz_s3, p_sy_s3, p_cz_s3;
	logic signed [26:0] x1_s3;
	// second rotation rounding
	logic signed [43:0] sum_y2, sum_z2;
	logic signed [26:0] x2_s4;
	logic signed [29:0] y2_s4, z2_s4;
	// depth and numerators
	logic signed [30:0] d_s5;
	logic signed [43:0] nx_s5;
	logic signed [46:0] ny_s5;
	// divider operands
	logic [46:0] ax, ay;
	logic [NUM_W-1:0] numx_s6, numy_s6, lim;
	logic [DEN_W-1:0] den_s6;
	logic inval_s6, sgnx_s6, sgny_s6, ovx_s6, ovy_s6;

	assign sum_x1 = 41'(p_cx_s1) + 41'(p_sz_s1) + 41'sd8192;
	assign sum_z1 = 41'(p_cz_s1) - 41'(p_sx_s1) + 41'sd8192;
	assign sum_y2 = 44'(p_cy_s3) - 44'(p_sz_s3) + 44'sd8192;
	assign sum_z2 = 44'(p_sy_s3) + 44'(p_cz_s3) + 44'sd8192;
	assign ax = nx_s5[43] ? 47'(-48'(nx_s5)) : 47'(nx_s5);
	assign ay = ny_s5[46] ? 47'(-48'(ny_s5)) : 47'(ny_s5);
	assign lim = NUM_W'({d_s5[29:0], 1'b0}) << QB;

	always_ff @(posedge clk) begin
		if (en) begin
			p_cx_s1 <= pitch_cos_q * vx;
			p_sz_s1 <= pitch_sin_q * vz;
			p_sx_s1 <= pitch_sin_q * vx;
			p_cz_s1 <= pitch_cos_q * vz;
			y_s1 <= vy;
			idx_s1 <= s_tdata[72 +: INDEX_BITS];
			last_s1 <= s_tlast;

			x1_s2 <= 27'(sum_x1 >>> 14);
			z1_s2 <= 27'(sum_z1 >>> 14);
			y1_s2 <= 27'(y_s1);
			idx_s2 <= idx_s1;
			last_s2 <= last_s1;

			p_cy_s3 <= yaw_cos_q * y1_s2;
			p_sz_s3 <= yaw_sin_q * z1_s2;
			p_sy_s3 <= yaw_sin_q * y1_s2;
			p_cz_s3 <= yaw_cos_q * z1_s2;
			x1_s3 <= x1_s2;
			idx_s3 <= idx_s2;
			last_s3 <= last_s2;

			y2_s4 <= 30'(sum_y2 >>> 14);
			z2_s4 <= 30'(sum_z2 >>> 14);
			x2_s4 <= x1_s3;
			idx_s4 <= idx_s3;
			last_s4 <= last_s3;

			d_s5 <= 31'(z2_s4) + 31'(depth_off_q);
			nx_s5 <= x2_s4 * $signed({1'b0, focal_q});
			ny_s5 <= y2_s4 * $signed({1'b0, focal_q});
			idx_s5 <= idx_s4;
			last_s5 <= last_s4;

			numx_s6 <= NUM_W'({ax, 1'b0}) + NUM_W'(d_s5[29:0]);
			numy_s6 <= NUM_W'({ay, 1'b0}) + NUM_W'(d_s5[29:0]);
			den_s6 <= DEN_W'({d_s5[29:0], 1'b0});
			ovx_s6 <= (NUM_W'({ax, 1'b0}) + NUM_W'(d_s5[29:0])) >= lim;
			ovy_s6 <= (NUM_W'({ay, 1'b0}) + NUM_W'(d_s5[29:0])) >= lim;
			inval_s6 <= d_s5[30] || (d_s5 == '0);
			sgnx_s6 <= nx_s5[43];
			sgny_s6 <= ny_s5[46];
			idx_s6 <= idx_s5;
			last_s6 <= last_s5;
		end
	end

	logic dv_valid;
	logic [QB-1:0] qx, qy;
	logic [TAG_W-1:0] tag_in, tag_out;

	assign ctl.en = en;
	assign ctl.valid = vld_s6;
	assign tag_in = {idx_s6, last_s6, inval_s6, sgnx_s6, sgny_s6, ovx_s6, ovy_s6};

	vrp_div #(
		.TAG_W(TAG_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.num_x(numx_s6),
		.num_y(numy_s6),
		.den(den_s6),
		.tag(tag_in),
		.out_valid(dv_valid),
		.quo_x(qx),
		.quo_y(qy),
		.out_tag(tag_out)
	);

	logic [INDEX_BITS-1:0] idx_d;
	logic last_d, inval_d, sgnx_d, sgny_d, ovx_d, ovy_d;
	assign {idx_d, last_d, inval_d, sgnx_d, sgny_d, ovx_d, ovy_d} = tag_out;

	// screen offsets, q.4, near 5/8 of width and 9/16 of height
	logic [13:0] dw, th;
	logic [18:0] cx, cy;
	assign dw = width_q >> 2;
	assign th = height_q >> 3;
	assign cx = 19'({dw, 4'b0}) + 19'({width_q - dw, 3'b0});
	assign cy = 19'({th, 4'b0}) + 19'({height_q - th, 3'b0});

	logic [QB:0] magx, magy;
	logic signed [23:0] sumx, sumy;
	logic signed [SCR_W-1:0] satx, saty;

	assign magx = ovx_d ? (QB+1)'(1) << QB : {1'b0, qx};
	assign magy = ovy_d ? (QB+1)'(1) << QB : {1'b0, qy};
	assign sumx = 24'(cx) + (sgnx_d ? -24'(magx) : 24'(magx));
	assign sumy = 24'(cy) + (sgny_d ? -24'(magy) : 24'(magy));

	always_comb begin
		priority if (sumx > 24'(SAT_MAX)) satx = SAT_MAX;
		else if (sumx < 24'(SAT_MIN)) satx = SAT_MIN;
		else satx = SCR_W'(sumx);
		priority if (sumy > 24'(SAT_MAX)) saty = SAT_MAX;
		else if (sumy < 24'(SAT_MIN)) saty = SAT_MIN;
		else saty = SCR_W'(sumy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= OUT_W'({idx_d, inval_d ? {SCR_W{1'b0}} : saty,
				inval_d ? {SCR_W{1'b0}} : satx});
			m_tuser <= inval_d;
			m_tlast <= last_d;
		end
	end

	assign m_tvalid = out_vld_q;

	`VRP_ASSERT(a_inval_zero, (m_tvalid && m_tuser[0]) |-> (m_tdata[39:0] == '0))
	`VRP_ASSERT(a_ovx_sat, (en && dv_valid && !inval_d && ovx_d && !sgnx_d) |=> (m_tdata[19:0] == SAT_MAX))
	`VRP_ASSERT(a_ovy_sat, (en && dv_valid && !inval_d && ovy_d && sgny_d) |=> (m_tdata[39:20] == SAT_MIN))
endmodule
